@@ src/kd_pkg.sv @@
// Shared widths, register indexes and transfer types for the knapsack decrypt unit.
`default_nettype none
package kd_pkg;
    localparam int WORD_W           = 63;
    localparam int BITS_W           = 64;
    localparam int IDX_W            = 6;
    localparam int SIZE_W           = 7;
    localparam int CFG_IDX_W        = 2;
    localparam int CNT_W            = 6;
    localparam int MAX_ELEMENTS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE       = 2'd2;

    // remainder token travelling down the cell row
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] rem;
    } kd_flow_t;

    // element write broadcast to every cell
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] value;
    } kd_load_t;

    // request to the serial modular unit
    typedef struct packed {
        logic              div_mode;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] divisor;
        logic [WORD_W-1:0] addend;
        logic [WORD_W-1:0] modulus;
    } kd_mm_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] acc;
    } kd_mm_rsp_t;
endpackage
`default_nettype wire

@@ src/kd_modser.sv @@
// Bit-serial unit: restoring division and Horner-style modular multiply-accumulate.
`default_nettype none
module kd_modser import kd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire kd_mm_req_t req,
    output kd_mm_rsp_t      rsp
);
    kd_mm_req_t        req_reg;
    logic              busy_reg;
    logic              phase_reg;
    logic              bit_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] acc_reg;

    logic [WORD_W:0]   t_val;
    logic              t_ge;
    logic              bit_now;
    logic [WORD_W:0]   rem_next;
    logic [WORD_W:0]   dbl;
    logic [WORD_W:0]   dbl_red;
    logic [WORD_W:0]   sum;
    logic [WORD_W:0]   sum_red;

    always_comb begin
        t_val    = {rem_reg, word_reg[WORD_W-1]};
        t_ge     = t_val >= {1'b0, req_reg.divisor};
        bit_now  = req_reg.div_mode ? t_ge : word_reg[WORD_W-1];
        rem_next = t_ge ? t_val - {1'b0, req_reg.divisor} : t_val;
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, req_reg.modulus}) ? dbl - {1'b0, req_reg.modulus} : dbl;
        sum      = {1'b0, acc_reg} + (bit_reg ? {1'b0, req_reg.addend} : '0);
        sum_red  = (sum >= {1'b0, req_reg.modulus}) ? sum - {1'b0, req_reg.modulus} : sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                req_reg   <= req;
                word_reg  <= req.word;
                rem_reg   <= '0;
                acc_reg   <= '0;
                cnt_reg   <= CNT_W'(WORD_W - 1);
                phase_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (!phase_reg) begin
                    // take the next quotient/multiplier bit and double the accumulator
                    bit_reg   <= bit_now;
                    if (req_reg.div_mode)
                        rem_reg <= rem_next[WORD_W-1:0];
                    word_reg  <= {word_reg[WORD_W-2:0], 1'b0};
                    acc_reg   <= dbl_red[WORD_W-1:0];
                    phase_reg <= 1'b1;
                end else begin
                    acc_reg   <= sum_red[WORD_W-1:0];
                    phase_reg <= 1'b0;
                    if (cnt_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.acc  = acc_reg;
endmodule
`default_nettype wire

@@ src/kd_cell.sv @@
// One knapsack element cell: holds its element, tests and subtracts the passing remainder.
`default_nettype none
module kd_cell import kd_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kd_load_t          load,
    input  wire logic [SIZE_W-1:0] size_n,
    input  wire kd_flow_t          flow_in,
    output kd_flow_t               flow_out,
    output logic                   bit_out
);
    logic [WORD_W-1:0] elem_reg;
    logic              valid_reg;
    logic [WORD_W-1:0] rem_reg;
    logic              bit_reg;
    logic              take;

    assign take = (SIZE_W'(CELL_IDX) < size_n) && (flow_in.rem >= elem_reg);

    always_ff @(posedge aclk) begin
        if (load.en && load.idx == IDX_W'(CELL_IDX))
            elem_reg <= load.value;
        if (flow_in.valid) begin
            rem_reg <= take ? flow_in.rem - elem_reg : flow_in.rem;
            bit_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= flow_in.valid;
    end

    assign flow_out.valid = valid_reg;
    assign flow_out.rem   = rem_reg;
    assign bit_out        = bit_reg;
endmodule
`default_nettype wire

@@ src/knapsack_decrypt_unit.sv @@
// Top level: configuration, inverse search, modular product and the element cell row.
//
//  channel | signals                                           | role
//  s_      | s_valid s_ready s_mode s_element_index ...        | load element / ciphertext in
//  m_      | m_valid m_ready m_plain_bits                      | recovered bit word out
//  cfg_    | cfg_wr_en cfg_index cfg_wr_data                   | register writes
//
// Load transaction: the element is written to its cell when accepted. Decrypt: the serial
// modular product (a double and an add phase per multiplier bit), then the cell row walk.
// With a modulus of two or more, the first decrypt after reset or a modulus/multiplier write
// also reduces the multiplier and, unless that is zero, runs the serial Euclid search.
// Reset is synchronous; element storage is not cleared. A stalled result is held in the
// output register while the next transaction is taken.
`default_nettype none
module knapsack_decrypt_unit import kd_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [IDX_W-1:0]     s_element_index,
    input  wire logic [WORD_W-1:0]    s_element_value,
    input  wire logic [WORD_W-1:0]    s_cipher_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [BITS_W-1:0]         m_plain_bits
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MODW, ST_EUCLID, ST_MUL, ST_WALK, ST_HOLD
    } state_t;

    state_t            state_reg;
    logic [WORD_W-1:0] modulus_reg, multiplier_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [WORD_W-1:0] inv_reg;
    logic              inv_ready_reg;
    logic [WORD_W-1:0] cw_reg;
    logic [WORD_W-1:0] r1_reg, t0_reg, t1_reg;
    logic              start_reg;
    kd_mm_req_t        req_reg;
    kd_flow_t          inj_reg;
    logic              m_valid_reg;
    logic [BITS_W-1:0] bits_reg;

    kd_mm_rsp_t        rsp;
    kd_load_t          load;
    kd_flow_t          flows [MAX_ELEMENTS+1];
    logic [MAX_ELEMENTS-1:0] cell_bits;
    logic [MAX_ELEMENTS-1:0] chain_valid;
    logic [SIZE_W-1:0] size_n;
    logic              accept;
    logic              small_mod;
    logic [WORD_W:0]   tn_wide;
    logic [WORD_W-1:0] tn;
    logic              idle_dec;
    logic              start_next;
    logic              inj_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign small_mod = modulus_reg < WORD_W'(2);
    assign size_n    = (size_reg > SIZE_W'(MAX_ELEMENTS)) ? SIZE_W'(MAX_ELEMENTS) : size_reg;
    assign tn_wide   = (t0_reg >= rsp.acc) ? {1'b0, t0_reg - rsp.acc}
                     : {1'b0, t0_reg} + {1'b0, modulus_reg} - {1'b0, rsp.acc};
    assign tn        = tn_wide[WORD_W-1:0];

    assign idle_dec   = (state_reg == ST_IDLE) && accept && s_mode;
    assign start_next = (idle_dec && !small_mod)
                      || ((state_reg inside {ST_MODW, ST_EUCLID}) && rsp.done);
    assign inj_next   = (idle_dec && small_mod) || (state_reg == ST_MUL && rsp.done);

    assign load.en    = accept && !s_mode && (s_element_index < IDX_W'(MAX_ELEMENTS - 1)
                        || s_element_index == IDX_W'(MAX_ELEMENTS - 1));
    assign load.idx   = s_element_index;
    assign load.value = s_element_value;

    kd_modser u_modser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .req     (req_reg),
        .rsp     (rsp)
    );

    assign flows[MAX_ELEMENTS] = inj_reg;

    for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
        kd_cell #(.CELL_IDX(k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load     (load),
            .size_n   (size_n),
            .flow_in  (flows[k+1]),
            .flow_out (flows[k]),
            .bit_out  (cell_bits[k])
        );
        assign chain_valid[k] = flows[k].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            modulus_reg    <= WORD_W'(2);
            multiplier_reg <= WORD_W'(1);
            size_reg       <= SIZE_W'(64);
            inv_reg        <= '0;
            inv_ready_reg  <= 1'b0;
            start_reg      <= 1'b0;
            inj_reg.valid  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            start_reg     <= start_next;
            inj_reg.valid <= inj_next;
            // the hold state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_HOLD)
                m_valid_reg <= 1'b0;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MODULUS: begin
                        modulus_reg   <= cfg_wr_data;
                        inv_ready_reg <= 1'b0;
                    end
                    CFG_MULTIPLIER: begin
                        multiplier_reg <= cfg_wr_data;
                        inv_ready_reg  <= 1'b0;
                    end
                    CFG_SIZE: size_reg <= cfg_wr_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_mode) begin
                        cw_reg <= s_cipher_word;
                        if (small_mod) begin
                            inj_reg.rem   <= '0;
                            state_reg     <= ST_WALK;
                        end else if (!inv_ready_reg) begin
                            // reduce the multiplier first
                            req_reg   <= '{1'b1, multiplier_reg, modulus_reg, '0, modulus_reg};
                            state_reg <= ST_MODW;
                        end else begin
                            req_reg   <= '{1'b0, s_cipher_word, modulus_reg, inv_reg,
                                           modulus_reg};
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MODW: begin
                    if (rsp.done) begin
                        if (rsp.rem == '0) begin
                            inv_reg       <= '0;
                            inv_ready_reg <= 1'b1;
                            req_reg       <= '{1'b0, cw_reg, modulus_reg, '0, modulus_reg};
                            state_reg     <= ST_MUL;
                        end else begin
                            r1_reg    <= rsp.rem;
                            t0_reg    <= '0;
                            t1_reg    <= WORD_W'(1);
                            req_reg   <= '{1'b1, modulus_reg, rsp.rem, WORD_W'(1), modulus_reg};
                            state_reg <= ST_EUCLID;
                        end
                    end
                end
                ST_EUCLID: begin
                    if (rsp.done) begin
                        if (rsp.rem == '0) begin
                            inv_reg       <= t1_reg;
                            inv_ready_reg <= 1'b1;
                            req_reg       <= '{1'b0, cw_reg, modulus_reg, t1_reg, modulus_reg};
                            state_reg     <= ST_MUL;
                        end else begin
                            // advance one Euclid step
                            r1_reg    <= rsp.rem;
                            t0_reg    <= t1_reg;
                            t1_reg    <= tn;
                            req_reg   <= '{1'b1, r1_reg, rsp.rem, tn, modulus_reg};
                        end
                    end
                end
                ST_MUL: begin
                    if (rsp.done) begin
                        inj_reg.rem   <= rsp.acc;
                        state_reg     <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (flows[0].valid)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        bits_reg    <= BITS_W'(cell_bits);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_plain_bits = bits_reg;

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_valid))
        else $error("more than one remainder in the cell row");

    a_stale_inverse: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (cfg_index == CFG_MODULUS || cfg_index == CFG_MULTIPLIER)
        |=> !inv_ready_reg)
        else $error("inverse still marked ready after a key write");

    a_result_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_HOLD))
        else $error("result raised outside the hold state");
endmodule
`default_nettype wire

@@ dv/tb_knapsack_decrypt_unit.sv @@
// Self-checking testbench for the knapsack decrypt unit: directed cases, back-pressure, key sets and noise.
`default_nettype none
module tb_knapsack_decrypt_unit;
    import kd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 10000000;
    localparam int          SETTLE      = 400;
    localparam int          LOAD_COUNT  = 1200;
    localparam int          LONG_HOLD   = 600;
    localparam logic [62:0] WORD_MAX    = {WORD_W{1'b1}};
    localparam bit          LOAD        = 1'b0;
    localparam bit          DECRYPT     = 1'b1;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_MODULUS;
    logic [WORD_W-1:0]    cfg_wr_data     = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_mode          = LOAD;
    logic [IDX_W-1:0]     s_element_index = '0;
    logic [WORD_W-1:0]    s_element_value = '0;
    logic [WORD_W-1:0]    s_cipher_word   = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [BITS_W-1:0]    m_plain_bits;

    knapsack_decrypt_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_element_index(s_element_index), .s_element_value(s_element_value),
        .s_cipher_word(s_cipher_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_plain_bits(m_plain_bits)
    );

    // shadow of the block's state
    logic [62:0] elem_tab [MAX_ELEMENTS_DEF];
    logic [62:0] mod_reg, mult_reg, inv_val;
    logic [6:0]  size_reg;
    bit          inv_valid;

    logic [63:0] plain_q [$];
    int          errors, words_sent, items_sent, results_seen, cycles, long_hold, keysets;
    int          hold_req, hold_done;
    bit          calm;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, plain_q.size());
            $display("tb_knapsack_decrypt_unit: FAIL");
            $finish;
        end
    end

    // result side: random stall bursts plus one long hold-off on request
    int stall_left;
    always @(posedge aclk) begin
        if (hold_done != hold_req) begin
            m_ready   <= 1'b0;
            long_hold <= LONG_HOLD - 1;
            hold_done <= hold_req;
        end else if (long_hold > 0) begin
            m_ready   <= 1'b0;
            long_hold <= long_hold - 1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(1, 15) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (plain_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_plain_bits);
                errors++;
            end else begin
                want = plain_q.pop_front();
                if (m_plain_bits !== want) begin
                    $display("%0t: plain_bits mismatch, expected %h actual %h",
                             $time, want, m_plain_bits);
                    errors++;
                end
            end
        end
    end

    function automatic logic [62:0] mul_mod(logic [62:0] a, logic [62:0] b, logic [62:0] m);
        logic [127:0] p;
        if (m < 2) return '0;
        p = {65'd0, a} * {65'd0, b};
        return 63'(p % {65'd0, m});
    endfunction

    function automatic logic [62:0] euclid_inverse(logic [62:0] w, logic [62:0] m);
        logic [63:0] r0, r1, t0, t1, q, rn, tn;
        if (m < 2) return '0;
        r0 = 64'(m);
        r1 = 64'(w % m);
        if (r1 == 0) return '0;
        t0 = 0;
        t1 = 1;
        forever begin
            q  = r0 / r1;
            rn = r0 % r1;
            if (rn == 0) break;
            tn = (t0 + 64'(m) - 64'(mul_mod(63'(q % 64'(m)), 63'(t1), m))) % 64'(m);
            r0 = r1;
            r1 = rn;
            t0 = t1;
            t1 = tn;
        end
        return 63'(t1);
    endfunction

    function automatic logic [63:0] recover_bits(logic [62:0] cw);
        logic [62:0] rem;
        logic [63:0] bits;
        int          n;
        bits = '0;
        if (!inv_valid) begin
            inv_val   = euclid_inverse(mult_reg, mod_reg);
            inv_valid = 1'b1;
        end
        rem = mul_mod(cw, inv_val, mod_reg);
        n   = (size_reg > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : int'(size_reg);
        for (int k = n - 1; k >= 0; k--) begin
            if (rem >= elem_tab[k]) begin
                bits[k] = 1'b1;
                rem     = rem - elem_tab[k];
            end
        end
        return bits;
    endfunction

    function automatic logic [62:0] rand_word();
        return 63'({$urandom, $urandom});
    endfunction

    // random word with a random number of significant bits
    function automatic logic [62:0] rand_scaled();
        return rand_word() >> $urandom_range(0, 62);
    endfunction

    function automatic logic [62:0] gcd(logic [62:0] a, logic [62:0] b);
        logic [62:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // leaves valid high on return so that the next transaction can follow back to back
    task automatic send_item(bit mode, logic [5:0] idx, logic [62:0] val, logic [62:0] cw);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_element_index <= idx;
        s_element_value <= val;
        s_cipher_word   <= cw;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (mode == LOAD) begin
            elem_tab[idx] = val;
        end else begin
            plain_q = {plain_q, recover_bits(cw)};
            words_sent++;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (plain_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_MODULUS:    begin mod_reg  = data; inv_valid = 1'b0; end
            CFG_MULTIPLIER: begin mult_reg = data; inv_valid = 1'b0; end
            CFG_SIZE:       size_reg = data[6:0];
            default:        ;
        endcase
    endtask

    task automatic set_regs(logic [62:0] m, logic [62:0] w, logic [6:0] n);
        wait_idle();
        write_reg(CFG_MODULUS, m);
        write_reg(CFG_MULTIPLIER, w);
        write_reg(CFG_SIZE, 63'(n));
    endtask

    task automatic test_directed();
        for (int j = 0; j < MAX_ELEMENTS_DEF; j++)
            send_item(LOAD, 6'(j), (j < 62) ? 63'(1) << j : (j == 62 ? '0 : WORD_MAX), '0);
        send_item(DECRYPT, '0, '0, '0);
        send_item(DECRYPT, '1, WORD_MAX, WORD_MAX);
        set_regs(63'd1000, 63'd7, 7'd0);               // zero size gives an empty result
        send_item(DECRYPT, '0, '0, 63'd123);
        wait_idle();
        write_reg(CFG_SIZE, 63'd127);                   // oversize saturates
        send_item(DECRYPT, '0, '0, 63'd999);
        set_regs('0, 63'd5, 7'd10);                     // modulus zero
        send_item(DECRYPT, '0, '0, 63'd77);
        set_regs(63'd1, 63'd5, 7'd10);                  // modulus one
        send_item(DECRYPT, '0, '0, 63'd77);
        set_regs(WORD_MAX, WORD_MAX - 1, 7'd64);        // largest modulus
        send_item(DECRYPT, '0, '0, WORD_MAX - 1);
        send_item(DECRYPT, '0, '0, 63'h5555_5555_5555_5555);
        set_regs(63'd97, 63'd194, 7'd6);                // multiplier a multiple of the modulus
        send_item(DECRYPT, '0, '0, 63'd50);
        set_regs(63'd12, 63'd8, 7'd4);                  // common factor
        send_item(DECRYPT, '0, '0, 63'd11);
        wait_idle();
        write_reg(CFG_MULTIPLIER, 63'd5);               // inverse must be recomputed
        send_item(DECRYPT, '0, '0, 63'd11);
        send_item(DECRYPT, '0, '0, 63'd3);
        wait_idle();
        write_reg(CFG_MODULUS, 63'd13);
        send_item(DECRYPT, '0, '0, 63'd9);
    endtask

    // build a superincreasing key, program it and send encrypted words with some noise
    task automatic run_keyset(int n, int words);
        logic [62:0] sum, m, w, c, a [MAX_ELEMENTS_DEF];
        logic [63:0] pick;
        int          sb;
        sum = '0;
        sb  = $urandom_range(0, 61 - n);
        for (int j = 0; j < n; j++) begin
            a[j] = sum + 1 + (sb == 0 ? '0 : rand_word() >> (63 - sb));
            sum  = sum + a[j];
        end
        m = sum + 1 + rand_word() % (WORD_MAX - sum);
        do w = 1 + rand_word() % (m - 1); while (gcd(m, w) != 1);
        set_regs(m, w, 7'(n));
        keysets++;
        for (int j = 0; j < n; j++) send_item(LOAD, 6'(j), a[j], rand_word());
        for (int i = 0; i < words; i++) begin
            pick = {$urandom, $urandom};
            c    = '0;
            for (int j = 0; j < n; j++)
                if (pick[j]) c = 63'((64'(c) + 64'(mul_mod(w, a[j], m))) % 64'(m));
            case ($urandom_range(0, 15))
                0:       send_item(DECRYPT, 6'($urandom), rand_word(), rand_word());
                1:       send_item(LOAD, 6'($urandom_range(n, 63)), rand_word(), rand_word());
                default: send_item(DECRYPT, 6'($urandom), rand_word(), c);
            endcase
        end
    endtask

    // random registers and table contents, including sizes above any superincreasing fit
    task automatic run_noise(int count);
        set_regs(rand_scaled(), rand_scaled(), 7'($urandom_range(0, 127)));
        for (int i = 0; i < count; i++)
            send_item(6'($urandom_range(0, 2)) != 0 ? DECRYPT : LOAD, 6'($urandom),
                      rand_scaled(), rand_word());
    endtask

    task automatic test_backpressure();
        int n;
        n = $urandom_range(4, 20);
        run_keyset(n, 2);
        hold_req++;
        for (int i = 0; i < 12; i++) send_item(DECRYPT, '0, '0, rand_word());
        wait_idle();
    endtask

    task automatic test_random();
        while (items_sent < LOAD_COUNT) begin
            if (items_sent > LOAD_COUNT - 200) calm = 1'b1;
            if ($urandom_range(0, 4) == 0)
                run_noise($urandom_range(5, 30));
            else
                run_keyset(($urandom_range(0, 3) == 0) ? $urandom_range(17, 60)
                                                        : $urandom_range(1, 16),
                           $urandom_range(10, 40));
        end
    endtask

    initial begin
        mod_reg   = 63'd2;
        mult_reg  = 63'd1;
        size_reg  = 7'd64;
        inv_val   = '0;
        inv_valid = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random();
        wait_idle();
        $display("sent %0d transactions, %0d ciphertext words over %0d key sets;",
                 items_sent, words_sent, keysets);
        $display("checked %0d results, %0d mismatches, %0d cycles", results_seen, errors, cycles);
        if (errors == 0)
            $display("tb_knapsack_decrypt_unit: PASS");
        else
            $display("tb_knapsack_decrypt_unit: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
